// File: src/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg
// Result kinds and character constants for the script tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

  typedef enum logic [2:0] {
    KIND_CHAR  = 3'd0,
    KIND_END   = 3'd1,
    KIND_EOS   = 3'd2,
    KIND_NLERR = 3'd3,
    KIND_LONG  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  token_char;
    logic [19:0] line_number;
    logic        last_of_run;
  } res_t;

  localparam logic [7:0]  CH_NUL   = 8'h00;
  localparam logic [7:0]  CH_LF    = 8'h0A;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_QUOTE = 8'h22;
  localparam logic [7:0]  CH_SLASH = 8'h2F;
  localparam logic [7:0]  CH_SEMI  = 8'h3B;
  localparam logic [7:0]  CH_HIGH  = 8'h80;
  localparam logic [19:0] LINE_MAX = 20'hFFFFF;

endpackage

// File: src/script_tokenizer.sv
// ----------------------------------------------------------------------------
// script_tokenizer
// Splits script text into tokens, skipping blanks and line comments.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one text byte per request, with final_byte marking the last byte
//           of a script and allow_newline letting the token search cross
//           newlines and comments.
//   out_* : results, one per request: token chars, token end, end of script,
//           newline error, token too long. last_of_run marks the last result
//           of one text byte; a byte gives zero to three results.
// Output: the results of a byte are registered in the result queue when it is taken.
// Flow: a new byte is taken while the four-entry result queue holds fewer
//   than two results; in_stall is high while the queue holds two or more
//   results, so bytes that give several results hold the input side.
// Reset: state seeks the next token, line count is one, queue is empty.
// End of script: the final byte resets scan state and line count.
// Receiver stall: the head result holds; once the queue holds two results
//   the input side stalls.
// ----------------------------------------------------------------------------
module script_tokenizer #(
  parameter int MAX_TOKEN_LEN = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_final_byte,
  input  logic        in_allow_newline,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_token_char,
  output logic [19:0] out_line_number,
  output logic        out_last_of_run
);

  localparam logic [7:0] MAX_LEN = 8'(MAX_TOKEN_LEN);
  localparam int QDEPTH = 4;

  typedef enum logic [2:0] {
    PH_SEEK    = 3'd0,
    PH_COMMENT = 3'd1,
    PH_SLASH   = 3'd2,
    PH_QPEND   = 3'd3,
    PH_PLAIN   = 3'd4,
    PH_QUOTED  = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t                        ph;
    logic [7:0]                    held;
    logic [7:0]                    tlen;
    logic [19:0]                   line;
    logic [1:0]                    n;
    stok_pkg::kind_t [2:0]         kind;
    logic [2:0][7:0]               ch;
    logic [2:0][19:0]              ln;
  } scan_t;

  function automatic scan_t emit_f(scan_t s, stok_pkg::kind_t k, logic [7:0] c);
    scan_t r;
    r = s;
    if (s.n != 2'd3) begin
      r.kind[s.n] = k;
      r.ch[s.n]   = c;
      r.ln[s.n]   = s.line;
      r.n         = s.n + 2'd1;
    end
    return r;
  endfunction

  function automatic scan_t bump_f(scan_t s);
    scan_t r;
    r = s;
    if (s.line != stok_pkg::LINE_MAX) r.line = s.line + 20'd1;
    return r;
  endfunction

  function automatic scan_t long_f(scan_t s);
    scan_t r;
    r      = emit_f(s, stok_pkg::KIND_LONG, 8'd0);
    r.ph   = PH_SEEK;
    r.tlen = 8'd0;
    return r;
  endfunction

  phase_t      phase_r;
  logic [7:0]  held_r;
  logic [7:0]  tlen_r;
  logic [19:0] line_r;

  stok_pkg::res_t queue_r [QDEPTH];
  logic [1:0]  wr_ptr_r;
  logic [1:0]  rd_ptr_r;
  logic [2:0]  count_r;
  logic [2:0]  count_nxt;

  scan_t       s;
  logic [7:0]  c;
  logic        fin;
  logic        err;
  logic        done;
  logic        in_acc;
  logic        out_acc;
  logic        plain_ch;
  logic        print_ch;

  assign in_stall = (count_r > 3'd1);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (count_r != 3'd0);
  assign out_acc  = out_valid && !out_stall;

  assign c   = in_text_byte;
  assign fin = in_final_byte;
  assign err = !in_allow_newline && !in_final_byte;

  assign plain_ch = (c > stok_pkg::CH_SPACE) && (c < stok_pkg::CH_HIGH) &&
                    (c != stok_pkg::CH_SEMI) && (c != stok_pkg::CH_QUOTE);
  assign print_ch = (c >= stok_pkg::CH_SPACE) && (c < stok_pkg::CH_HIGH);

  // up to four passes: a byte may close one token state and then be rescanned
  always_comb begin
    s      = '0;
    s.ph   = phase_r;
    s.held = held_r;
    s.tlen = tlen_r;
    s.line = line_r;
    done   = 1'b0;
    for (int p = 0; p < 4; p++) begin
      if (!done) begin
        unique case (s.ph)
          PH_COMMENT: begin
            if (c == stok_pkg::CH_LF) begin
              s    = bump_f(s);
              s.ph = PH_SEEK;
            end
            done = 1'b1;
          end
          PH_SLASH: begin
            if (c == stok_pkg::CH_SLASH) begin
              if (err) s = emit_f(s, stok_pkg::KIND_NLERR, 8'd0);
              s.ph = PH_COMMENT;
              done = 1'b1;
            end else begin
              s      = emit_f(s, stok_pkg::KIND_CHAR, s.held);
              s.tlen = 8'd1;
              s.ph   = PH_PLAIN;
              if (!fin && s.tlen >= MAX_LEN) begin
                s    = long_f(s);
                done = 1'b1;
              end
            end
          end
          PH_QPEND: begin
            if (c != stok_pkg::CH_NUL) begin
              s      = emit_f(s, stok_pkg::KIND_CHAR, s.held);
              s.tlen = 8'd1;
              s.ph   = PH_QUOTED;
              if (!fin && s.tlen >= MAX_LEN) begin
                s    = long_f(s);
                done = 1'b1;
              end
            end else begin
              // quote before zero: empty token
              s    = emit_f(s, stok_pkg::KIND_END, 8'd0);
              s.ph = PH_SEEK;
            end
          end
          PH_PLAIN: begin
            if (plain_ch) begin
              s = emit_f(s, stok_pkg::KIND_CHAR, c);
              if (s.tlen != 8'd255) s.tlen = s.tlen + 8'd1;
              if (!fin && s.tlen >= MAX_LEN) s = long_f(s);
              done = 1'b1;
            end else begin
              s    = emit_f(s, stok_pkg::KIND_END, 8'd0);
              s.ph = PH_SEEK;
            end
          end
          PH_QUOTED: begin
            if (c == stok_pkg::CH_QUOTE) begin
              s    = emit_f(s, stok_pkg::KIND_CHAR, c);
              s    = emit_f(s, stok_pkg::KIND_END, 8'd0);
              s.ph = PH_SEEK;
              done = 1'b1;
            end else if (print_ch) begin
              s = emit_f(s, stok_pkg::KIND_CHAR, c);
              if (s.tlen != 8'd255) s.tlen = s.tlen + 8'd1;
              if (!fin && s.tlen >= MAX_LEN) s = long_f(s);
              done = 1'b1;
            end else begin
              s    = emit_f(s, stok_pkg::KIND_END, 8'd0);
              s.ph = PH_SEEK;
            end
          end
          default: begin
            s.ph = PH_SEEK;
            done = 1'b1;
            if (c == stok_pkg::CH_LF) begin
              if (err) s = emit_f(s, stok_pkg::KIND_NLERR, 8'd0);
              s = bump_f(s);
            end else if (c <= stok_pkg::CH_SPACE || c >= stok_pkg::CH_HIGH) begin
              s.ph = PH_SEEK;
            end else if (c == stok_pkg::CH_SEMI) begin
              if (err) s = emit_f(s, stok_pkg::KIND_NLERR, 8'd0);
              s.ph = PH_COMMENT;
            end else if (c == stok_pkg::CH_SLASH) begin
              if (fin) begin
                s      = emit_f(s, stok_pkg::KIND_CHAR, c);
                s.tlen = 8'd1;
                s.ph   = PH_PLAIN;
              end else begin
                s.held = c;
                s.ph   = PH_SLASH;
              end
            end else if (c == stok_pkg::CH_QUOTE) begin
              if (!fin) begin
                s.held = c;
                s.ph   = PH_QPEND;
              end
            end else begin
              s.tlen = 8'd0;
              s.ph   = PH_PLAIN;
              done   = 1'b0;
            end
          end
        endcase
      end
    end
    if (fin) begin
      // end of script replaces a trailing token end
      if (s.n != 2'd0 && s.kind[s.n - 2'd1] == stok_pkg::KIND_END) begin
        s.kind[s.n - 2'd1] = stok_pkg::KIND_EOS;
        s.ch[s.n - 2'd1]   = 8'd0;
        s.ln[s.n - 2'd1]   = s.line;
      end else begin
        s = emit_f(s, stok_pkg::KIND_EOS, 8'd0);
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (out_acc) count_nxt = count_nxt - 3'd1;
    if (in_acc) count_nxt = count_nxt + {1'b0, s.n};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEEK;
      held_r   <= 8'd0;
      tlen_r   <= 8'd0;
      line_r   <= 20'd1;
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      if (in_acc) begin
        if (fin) begin
          phase_r <= PH_SEEK;
          held_r  <= 8'd0;
          tlen_r  <= 8'd0;
          line_r  <= 20'd1;
        end else begin
          phase_r <= s.ph;
          held_r  <= s.held;
          tlen_r  <= s.tlen;
          line_r  <= s.line;
        end
        wr_ptr_r <= wr_ptr_r + s.n;
      end
      if (out_acc) rd_ptr_r <= rd_ptr_r + 2'd1;
      count_r <= count_nxt;
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < s.n) begin
          queue_r[wr_ptr_r + 2'(i)].kind        <= s.kind[i];
          queue_r[wr_ptr_r + 2'(i)].token_char  <= s.ch[i];
          queue_r[wr_ptr_r + 2'(i)].line_number <= s.ln[i];
          queue_r[wr_ptr_r + 2'(i)].last_of_run <= (2'(i) == s.n - 2'd1);
        end
      end
    end
  end

  assign out_kind        = queue_r[rd_ptr_r].kind;
  assign out_token_char  = queue_r[rd_ptr_r].token_char;
  assign out_line_number = queue_r[rd_ptr_r].line_number;
  assign out_last_of_run = queue_r[rd_ptr_r].last_of_run;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(QDEPTH))
    else $error("result queue overflow");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[1:0])
    else $error("queue pointers and count disagree");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != 20'd0)
    else $error("line count reached zero");

  a_tlen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tlen_r < MAX_LEN)
    else $error("token length not cut at limit");

  a_final_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_final_byte |=> line_r == 20'd1 && phase_r == PH_SEEK)
    else $error("state not restored after end of script");
`endif

endmodule
